/* rtl/core/biq_pkg.sv */
package biq_pkg;

    localparam int DEF_SAMPLE_WIDTH   = 16;
    localparam int DEF_COEF_FRAC_BITS = 16;

    // Coefficients are Q3.F: sign, three integer bits and F fraction bits.
    localparam int COEF_INT_BITS   = 4;
    localparam int NUM_COEFS       = 5;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } coef_index_t;

endpackage

/* rtl/core/biq_if.sv */
interface biq_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           last_in_frame;

    modport source (output valid, output sample_in, output last_in_frame, input ready);
    modport sink   (input valid, input sample_in, input last_in_frame, output ready);
endinterface

interface biq_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           frame_end;

    modport source (output valid, output sample_out, output frame_end, input ready);
    modport sink   (input valid, input sample_out, input frame_end, output ready);
endinterface

/* rtl/core/biq_fifo.sv */
module biq_fifo
    import biq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/biq_front.sv */
module biq_front
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int CW = COEF_FRAC_BITS + COEF_INT_BITS,
    localparam int PW = CW + SAMPLE_WIDTH,
    localparam int EW = 3 * PW + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    biq_in_if.sink               samples,
    input  logic signed [CW-1:0] coef_b0,
    input  logic signed [CW-1:0] coef_b1,
    input  logic signed [CW-1:0] coef_b2,
    output logic                 push_valid,
    input  logic                 push_ready,
    output logic [EW-1:0]        push_data
);

    logic signed [SAMPLE_WIDTH-1:0] x1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x1_next;
    logic signed [SAMPLE_WIDTH-1:0] x2_reg;
    logic signed [SAMPLE_WIDTH-1:0] x2_next;
    logic signed [PW-1:0]           prod0;
    logic signed [PW-1:0]           prod1;
    logic signed [PW-1:0]           prod2;
    logic                           accept;

    assign samples.ready = push_ready;
    assign push_valid    = samples.valid;
    assign accept        = samples.valid && push_ready;

    assign prod0 = PW'(coef_b0) * PW'(samples.sample_in);
    assign prod1 = PW'(coef_b1) * PW'(x1_reg);
    assign prod2 = PW'(coef_b2) * PW'(x2_reg);

    assign push_data = {samples.last_in_frame, prod2, prod1, prod0};

    always_comb
    begin
        x1_next = x1_reg;
        x2_next = x2_reg;
        if (accept)
        begin
            if (samples.last_in_frame)
            begin
                x1_next = '0;
                x2_next = '0;
            end
            else
            begin
                x1_next = samples.sample_in;
                x2_next = x1_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
        end
        else
        begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
    end

endmodule

/* rtl/core/biq_back.sv */
module biq_back
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int CW = COEF_FRAC_BITS + COEF_INT_BITS,
    localparam int PW = CW + SAMPLE_WIDTH,
    localparam int EW = 3 * PW + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  logic [EW-1:0]        pop_data,
    input  logic signed [CW-1:0] coef_a1,
    input  logic signed [CW-1:0] coef_a2,
    biq_out_if.source            filtered
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = COEF_FRAC_BITS;
    localparam int YW  = W + F;
    localparam int FW  = CW + YW;
    localparam int AW  = W + 2 * F + 7;
    localparam int AW1 = AW + 1;

    localparam logic [AW:0] HALF_F  = AW1'(1) << (F - 1);
    localparam logic [AW:0] HALF_2F = AW1'(1) << (2 * F - 1);
    localparam logic signed [AW:0] Y_HI = {{(AW1 - YW + 1){1'b0}}, {(YW - 1){1'b1}}};
    localparam logic signed [AW:0] Y_LO = {{(AW1 - YW + 1){1'b1}}, {(YW - 1){1'b0}}};
    localparam logic signed [AW:0] S_HI = {{(AW1 - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [AW:0] S_LO = {{(AW1 - W + 1){1'b1}}, {(W - 1){1'b0}}};

    logic signed [PW-1:0]  prod0;
    logic signed [PW-1:0]  prod1;
    logic signed [PW-1:0]  prod2;
    logic                  last;
    logic signed [PW+1:0]  ff_sum;
    logic signed [FW-1:0]  fb1;
    logic signed [FW-1:0]  fb2;
    logic signed [AW-1:0]  acc;
    logic signed [AW:0]    rnd_f;
    logic signed [AW:0]    rnd_2f;
    logic signed [AW:0]    q_f;
    logic signed [AW:0]    q_2f;
    logic signed [YW-1:0]  y_store;
    logic signed [W-1:0]   y_out;
    logic                  pop;

    logic signed [YW-1:0]  y1_reg;
    logic signed [YW-1:0]  y1_next;
    logic signed [YW-1:0]  y2_reg;
    logic signed [YW-1:0]  y2_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic signed [W-1:0]   sample_out_reg;
    logic signed [W-1:0]   sample_out_next;
    logic                  frame_end_reg;
    logic                  frame_end_next;

    assign prod0 = pop_data[PW-1:0];
    assign prod1 = pop_data[2*PW-1:PW];
    assign prod2 = pop_data[3*PW-1:2*PW];
    assign last  = pop_data[EW-1];

    assign pop_ready = !out_valid_reg || filtered.ready;
    assign pop       = pop_valid && pop_ready;

    assign ff_sum = (PW+2)'(prod0) + (PW+2)'(prod1) + (PW+2)'(prod2);
    assign fb1    = FW'(coef_a1) * FW'(y1_reg);
    assign fb2    = FW'(coef_a2) * FW'(y2_reg);
    assign acc    = (AW'(ff_sum) <<< F) - AW'(fb1) - AW'(fb2);

    // Half away from zero: a negative value adds one less than half before the floor shift.
    assign rnd_f  = AW1'(acc) + HALF_F - AW1'(acc[AW-1]);
    assign rnd_2f = AW1'(acc) + HALF_2F - AW1'(acc[AW-1]);
    assign q_f    = rnd_f >>> F;
    assign q_2f   = rnd_2f >>> (2 * F);

    always_comb
    begin
        if (q_f > Y_HI)
        begin
            y_store = YW'(Y_HI);
        end
        else if (q_f < Y_LO)
        begin
            y_store = YW'(Y_LO);
        end
        else
        begin
            y_store = q_f[YW-1:0];
        end

        if (q_2f > S_HI)
        begin
            y_out = W'(S_HI);
        end
        else if (q_2f < S_LO)
        begin
            y_out = W'(S_LO);
        end
        else
        begin
            y_out = q_2f[W-1:0];
        end
    end

    always_comb
    begin
        y1_next         = y1_reg;
        y2_next         = y2_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        frame_end_next  = frame_end_reg;
        if (filtered.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next  = 1'b1;
            sample_out_next = y_out;
            frame_end_next  = last;
            if (last)
            begin
                y1_next = '0;
                y2_next = '0;
            end
            else
            begin
                y1_next = y_store;
                y2_next = y1_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg        <= '0;
            y2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            y1_reg        <= y1_next;
            y2_reg        <= y2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_out_reg <= sample_out_next;
        frame_end_reg  <= frame_end_next;
    end

    assign filtered.valid      = out_valid_reg;
    assign filtered.sample_out = sample_out_reg;
    assign filtered.frame_end  = frame_end_reg;

endmodule

/* rtl/core/biquad_iir_filter_integer_samples.sv */
// Second-order IIR filter in direct form I with five programmable coefficients.
// Input samples arrive as beats on the samples channel and filtered samples
// leave as beats on the filtered channel, one result beat for each input beat,
// in order.
// Coefficients b0, b1, b2, a1 and a2 are written through cfg_we, cfg_index and
// cfg_data; the user must write only while no beat is in flight, which the block
// does not enforce. Indexes beyond a2 are ignored. An accepted beat is registered
// in the queue and its result then in the output register; the block takes one
// beat per cycle while the receiver keeps taking beats. That rate is set by the
// feedback path, whose two products, sum, rounding and saturation are combinational.
// The feedforward products are formed at the input and held in a two-entry
// queue, so the input side keeps accepting beats while a result waits.
// When the receiver stalls, the output register holds its beat, the queue fills
// and then the samples ready drops until the receiver takes a beat again.
// Reset clears the past inputs, the past outputs and the queue, and loads b0
// with one and the other coefficients with zero. A beat flagged last in frame
// is filtered with the current history and then clears that history.
module biquad_iir_filter_integer_samples
    import biq_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
    localparam int CW = COEF_FRAC_BITS + COEF_INT_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    biq_in_if.sink                     samples,
    biq_out_if.source                  filtered,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CW-1:0]              cfg_data
);

    localparam int PW = CW + SAMPLE_WIDTH;
    localparam int EW = 3 * PW + 1;

    logic signed [CW-1:0] coef_reg [NUM_COEFS];
    logic signed [CW-1:0] coef_next [NUM_COEFS];
    logic                 push_valid;
    logic                 push_ready;
    logic [EW-1:0]        push_data;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [EW-1:0]        pop_data;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_we)
        begin
            case (coef_index_t'(cfg_index))
                REG_B0:  coef_next[REG_B0] = cfg_data;
                REG_B1:  coef_next[REG_B1] = cfg_data;
                REG_B2:  coef_next[REG_B2] = cfg_data;
                REG_A1:  coef_next[REG_A1] = cfg_data;
                REG_A2:  coef_next[REG_A2] = cfg_data;
                default: coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[REG_B0] <= CW'(1) << COEF_FRAC_BITS;
            coef_reg[REG_B1] <= '0;
            coef_reg[REG_B2] <= '0;
            coef_reg[REG_A1] <= '0;
            coef_reg[REG_A2] <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    biq_front #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .coef_b0    (coef_reg[REG_B0]),
        .coef_b1    (coef_reg[REG_B1]),
        .coef_b2    (coef_reg[REG_B2]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    biq_fifo #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    biq_back #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .coef_a1   (coef_reg[REG_A1]),
        .coef_a2   (coef_reg[REG_A2]),
        .filtered  (filtered)
    );

endmodule

/* sim/biquad_iir_filter_integer_samples_test.sv */
typedef logic signed [biq_pkg::DEF_SAMPLE_WIDTH-1:0] sample_t;
typedef logic signed [biq_pkg::DEF_COEF_FRAC_BITS+biq_pkg::COEF_INT_BITS-1:0] coef_t;
typedef logic signed [biq_pkg::DEF_SAMPLE_WIDTH+biq_pkg::DEF_COEF_FRAC_BITS-1:0] ystore_t;

class filter_scoreboard;
    typedef struct packed {
        sample_t sample;
        logic    frame_end;
    } filtered_beat_t;

    coef_t          coef [biq_pkg::NUM_COEFS];
    sample_t        x_prev1;
    sample_t        x_prev2;
    ystore_t        y_prev1;
    ystore_t        y_prev2;
    filtered_beat_t expected_q [$];
    int             failures;

    function new();
        coef[biq_pkg::REG_B0] = coef_t'(1 <<< biq_pkg::DEF_COEF_FRAC_BITS);
        coef[biq_pkg::REG_B1] = '0;
        coef[biq_pkg::REG_B2] = '0;
        coef[biq_pkg::REG_A1] = '0;
        coef[biq_pkg::REG_A2] = '0;
        x_prev1 = '0;
        x_prev2 = '0;
        y_prev1 = '0;
        y_prev2 = '0;
        failures = 0;
    endfunction

    function void write_coef(logic [biq_pkg::CFG_INDEX_WIDTH-1:0] index, coef_t value);
        if (index < biq_pkg::NUM_COEFS)
        begin
            coef[index] = value;
        end
    endfunction

    function longint round_half_away(longint v, int s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function void note_input(sample_t x, logic last);
        longint         feedforward;
        longint         acc;
        longint         y_store;
        longint         y_out;
        filtered_beat_t beat;
        feedforward = longint'(coef[biq_pkg::REG_B0]) * longint'(x)
                    + longint'(coef[biq_pkg::REG_B1]) * longint'(x_prev1)
                    + longint'(coef[biq_pkg::REG_B2]) * longint'(x_prev2);
        acc = (feedforward <<< biq_pkg::DEF_COEF_FRAC_BITS)
            - longint'(coef[biq_pkg::REG_A1]) * longint'(y_prev1)
            - longint'(coef[biq_pkg::REG_A2]) * longint'(y_prev2);
        y_store = clamp(round_half_away(acc, biq_pkg::DEF_COEF_FRAC_BITS), $bits(ystore_t));
        y_out = clamp(round_half_away(acc, 2 * biq_pkg::DEF_COEF_FRAC_BITS), $bits(sample_t));
        beat.sample = sample_t'(y_out);
        beat.frame_end = last;
        expected_q.push_back(beat);
        if (last)
        begin
            x_prev1 = '0;
            x_prev2 = '0;
            y_prev1 = '0;
            y_prev2 = '0;
        end
        else
        begin
            x_prev2 = x_prev1;
            x_prev1 = x;
            y_prev2 = y_prev1;
            y_prev1 = ystore_t'(y_store);
        end
    endfunction

    function void check_result(sample_t got_sample, logic got_end);
        filtered_beat_t beat;
        if (expected_q.size() == 0)
        begin
            $error("unexpected filtered beat: sample_out=%0d frame_end=%0b", got_sample, got_end);
            failures++;
            return;
        end
        beat = expected_q.pop_front();
        if (got_sample !== beat.sample)
        begin
            $error("sample_out: expected %0d, got %0d", beat.sample, got_sample);
            failures++;
        end
        if (got_end !== beat.frame_end)
        begin
            $error("frame_end: expected %0b, got %0b", beat.frame_end, got_end);
            failures++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module biquad_iir_filter_integer_samples_test;
    timeunit 1ns;
    timeprecision 1ps;

    import biq_pkg::*;

    localparam int CW               = DEF_COEF_FRAC_BITS + COEF_INT_BITS;
    localparam int RANDOM_ITEMS     = 1400;
    localparam int SEGMENTS         = 10;
    localparam int LAST_INDEX       = (1 << CFG_INDEX_WIDTH) - 1;
    localparam int SETTLE_CYCLES    = 4;
    localparam coef_t COEF_MAX      = coef_t'((1 <<< (CW - 1)) - 1);
    localparam coef_t COEF_MIN      = coef_t'(-(1 <<< (CW - 1)));
    localparam coef_t COEF_ONE      = coef_t'(1 <<< DEF_COEF_FRAC_BITS);
    localparam coef_t COEF_HALF     = coef_t'(1 <<< (DEF_COEF_FRAC_BITS - 1));
    localparam sample_t SAMPLE_MAX  = sample_t'((1 <<< (DEF_SAMPLE_WIDTH - 1)) - 1);
    localparam sample_t SAMPLE_MIN  = sample_t'(-(1 <<< (DEF_SAMPLE_WIDTH - 1)));

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CW-1:0]              cfg_data;
    int                         send_idle_pct;
    int                         take_idle_pct;
    int                         sent_count;
    filter_scoreboard           sb = new();

    biq_in_if  #(.SAMPLE_WIDTH(DEF_SAMPLE_WIDTH)) sample_ch ();
    biq_out_if #(.SAMPLE_WIDTH(DEF_SAMPLE_WIDTH)) filtered_ch ();

    biquad_iir_filter_integer_samples #(
        .SAMPLE_WIDTH  (DEF_SAMPLE_WIDTH),
        .COEF_FRAC_BITS(DEF_COEF_FRAC_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (sample_ch),
        .filtered (filtered_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && filtered_ch.valid && filtered_ch.ready)
        begin
            sb.check_result(filtered_ch.sample_out, filtered_ch.frame_end);
        end
        filtered_ch.ready <= rst_n && ($urandom_range(0, 99) >= take_idle_pct);
    end

    task automatic program_filter(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2);
        coef_t                      values [NUM_COEFS];
        logic [CFG_INDEX_WIDTH-1:0] spare;
        coef_t                      junk;
        values = '{b0, b1, b2, a1, a2};
        spare = CFG_INDEX_WIDTH'($urandom_range(NUM_COEFS, LAST_INDEX));
        junk = coef_t'($urandom);
        // A write to an index past the last coefficient must leave every coefficient alone.
        cfg_we <= 1'b1;
        cfg_index <= spare;
        cfg_data <= junk;
        @(posedge clk);
        sb.write_coef(spare, junk);
        for (int i = 0; i < NUM_COEFS; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= coef_index_t'(i);
            cfg_data <= values[i];
            @(posedge clk);
            sb.write_coef(coef_index_t'(i), values[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(sample_t x, logic last);
        if (sent_count < RANDOM_ITEMS / 3)
        begin
            send_idle_pct = 11;
            take_idle_pct = 85;
        end
        else if (sent_count < 2 * RANDOM_ITEMS / 3)
        begin
            send_idle_pct = 85;
            take_idle_pct = 11;
        end
        else
        begin
            send_idle_pct = 0;
            take_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample_in <= x;
        sample_ch.last_in_frame <= last;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_input(x, last);
        sent_count++;
    endtask

    task automatic drain_pipeline();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            1, 2: return sample_t'(int'($urandom_range(0, 512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t pick_coef();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
            1: return coef_t'($urandom);
            default: return coef_t'(int'($urandom_range(0, 2 * COEF_ONE)) - int'(COEF_ONE));
        endcase
    endfunction

    task automatic program_segment(int seg);
        case (seg)
            0: program_filter(coef_t'(4425), coef_t'(8850), coef_t'(4425),
                              coef_t'(-74908), coef_t'(27054));
            1: program_filter(COEF_HALF, COEF_HALF, '0, -COEF_HALF, '0);
            2: program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
            3: program_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
            4: program_filter(COEF_MIN, COEF_MAX, '0, COEF_MAX, COEF_MIN);
            default: program_filter(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                                    pick_coef());
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_in = '0;
        sample_ch.last_in_frame = 1'b0;
        send_idle_pct = 0;
        take_idle_pct = 0;
        sent_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coefficients after reset pass the sample straight through.
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample('0, 1'b0);
        send_sample(sample_t'(1), 1'b0);
        send_sample(sample_t'(-1), 1'b1);
        drain_pipeline();

        // Half of an odd sample lands exactly on a half and rounds away from zero.
        program_filter(COEF_HALF, '0, '0, '0, '0);
        send_sample(sample_t'(1), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(sample_t'(3), 1'b0);
        send_sample(sample_t'(-3), 1'b1);
        drain_pipeline();

        // Runaway gain drives both the stored and the emitted output into saturation.
        program_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        repeat (3) send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        repeat (2) send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        drain_pipeline();

        // A beat flagged last in frame still sees the old history, then clears it.
        program_filter(COEF_ONE, COEF_ONE, COEF_ONE, '0, '0);
        send_sample(sample_t'(100), 1'b0);
        send_sample(sample_t'(200), 1'b0);
        send_sample(sample_t'(300), 1'b1);
        send_sample(sample_t'(400), 1'b0);
        send_sample(sample_t'(500), 1'b1);
        drain_pipeline();

        sent_count = 0;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            program_segment(seg);
            repeat (RANDOM_ITEMS / SEGMENTS)
            begin
                send_sample(pick_sample(), $urandom_range(0, 19) == 0);
            end
            drain_pipeline();
        end

        repeat (10) @(posedge clk);
        if (sb.failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
